// ===== hdl/stq_pkg.sv =====
`default_nettype none

package stq_pkg;

	localparam int CMD_W  = 2;
	localparam int ID_W   = 16;
	localparam int TIME_W = 63;
	localparam int KIND_W = 3;

	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EXPIRE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic [KIND_W-1:0] KIND_ADDED    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_CANCEL   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_EXPIRED  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_NONE_DUE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FULL     = 3'd4;
	localparam logic [KIND_W-1:0] KIND_DUP      = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} stq_state_t;

	typedef struct packed {
		logic load;
		logic clr;
		logic rd;
		logic emit;
	} stq_cmd_t;

	typedef struct packed {
		logic scan_end;
		logic out_free;
		logic more;
	} stq_stat_t;

endpackage

`default_nettype wire

// ===== hdl/sorted_timer_queue.sv =====
// Channel  Handshake            Word
// in       in_valid/in_ready    command, timer_id, when_time
// out      out_valid/out_ready  kind, earliest_changed, found, expired_id,
//                               expired_time, next_valid, next_expiry, last
//
// Each command scans the table one entry a cycle through the slot memory read
// port, then loads its result into the output register. Expire runs one full
// scan per reported timer, rescanning while due timers remain. Command 3 is
// accepted and dropped. Reset clears all slot valid bits at once; no
// clearing pass. A new word is taken while the last result still waits in
// the output register; a stalled output holds the scan before its next
// result.
`default_nettype none

module sorted_timer_queue #(
	parameter int TABLE_DEPTH = 16,
	parameter int ID_BITS     = 16
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [stq_pkg::CMD_W-1:0]     command,
	input  wire  [stq_pkg::ID_W-1:0]      timer_id,
	input  wire  [stq_pkg::TIME_W-1:0]    when_time,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic [stq_pkg::KIND_W-1:0]    kind,
	output logic                          earliest_changed,
	output logic                          found,
	output logic [stq_pkg::ID_W-1:0]      expired_id,
	output logic [stq_pkg::TIME_W-1:0]    expired_time,
	output logic                          next_valid,
	output logic [stq_pkg::TIME_W-1:0]    next_expiry,
	output logic                          last
);
	import stq_pkg::*;

	stq_cmd_t  cmd;
	stq_stat_t stat;

	stq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.stat     (stat),
		.cmd      (cmd)
	);

	stq_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.command          (command),
		.timer_id         (timer_id),
		.when_time        (when_time),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.kind             (kind),
		.earliest_changed (earliest_changed),
		.found            (found),
		.expired_id       (expired_id),
		.expired_time     (expired_time),
		.next_valid       (next_valid),
		.next_expiry      (next_expiry),
		.last             (last)
	);

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("result loaded over a pending word");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid)
		else $error("loaded result not presented");

	a_no_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> !in_ready)
		else $error("input ready during scan");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind <= KIND_DUP))
		else $error("result kind out of range");

endmodule

`default_nettype wire

// ===== hdl/stq_ctrl.sv =====
`default_nettype none

module stq_ctrl (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [stq_pkg::CMD_W-1:0]    command,
	input  wire  stq_pkg::stq_stat_t     stat,
	output stq_pkg::stq_cmd_t            cmd
);
	import stq_pkg::*;

	stq_state_t state_q;
	stq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && command != CMD_UNUSED) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					state_d = stat.more ? ST_SCAN : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && command != CMD_UNUSED) begin
					cmd.load = 1'b1;
					cmd.clr  = 1'b1;
				end
			end
			ST_SCAN: begin
				cmd.rd = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.clr  = stat.more;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/stq_dp.sv =====
`default_nettype none

module stq_dp #(
	parameter int TABLE_DEPTH = 16,
	parameter int ID_BITS     = 16
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire  stq_pkg::stq_cmd_t       cmd,
	output stq_pkg::stq_stat_t            stat,
	input  wire  [stq_pkg::CMD_W-1:0]     command,
	input  wire  [stq_pkg::ID_W-1:0]      timer_id,
	input  wire  [stq_pkg::TIME_W-1:0]    when_time,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic [stq_pkg::KIND_W-1:0]    kind,
	output logic                          earliest_changed,
	output logic                          found,
	output logic [stq_pkg::ID_W-1:0]      expired_id,
	output logic [stq_pkg::TIME_W-1:0]    expired_time,
	output logic                          next_valid,
	output logic [stq_pkg::TIME_W-1:0]    next_expiry,
	output logic                          last
);
	import stq_pkg::*;

	localparam int IdxW = $clog2(TABLE_DEPTH);
	localparam int CntW = $clog2(TABLE_DEPTH + 1);
	localparam int IdW  = (ID_BITS < ID_W) ? ID_BITS : ID_W;

	// table storage
	logic [TIME_W-1:0]      mem_time [TABLE_DEPTH];
	logic [IdW-1:0]         mem_id   [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;

	// latched word
	logic [CMD_W-1:0]  cmd_q;
	logic [IdW-1:0]    id_q;
	logic [TIME_W-1:0] time_q;

	// scan pipeline
	logic [IdxW-1:0]   rd_ptr_q;
	logic              vld_s1;
	logic [IdxW-1:0]   idx_s1;
	logic [TIME_W-1:0] rd_time_s1;
	logic [IdW-1:0]    rd_id_s1;

	// scan results
	logic              dup_q;
	logic [IdxW-1:0]   hit_idx_q;
	logic              free_found_q;
	logic [IdxW-1:0]   free_idx_q;
	logic              min_any_q;
	logic [TIME_W-1:0] min_q;
	logic              pick_found_q;
	logic [IdxW-1:0]   pick_idx_q;
	logic [TIME_W-1:0] pick_time_q;
	logic [IdW-1:0]    pick_id_q;
	logic [CntW-1:0]   due_cnt_q;

	logic out_valid_q;

	logic e_valid, id_hit, due, counts, pick_better;
	logic is_add, is_cancel, is_expire, add_ok;

	assign is_add    = (cmd_q == CMD_ADD);
	assign is_cancel = (cmd_q == CMD_CANCEL);
	assign is_expire = (cmd_q == CMD_EXPIRE);
	assign add_ok    = is_add && !dup_q && free_found_q;

	assign e_valid = valid_q[idx_s1];
	assign id_hit  = e_valid && (rd_id_s1 == id_q);
	assign due     = e_valid && is_expire && (rd_time_s1 <= time_q);
	assign counts  = e_valid && !(is_cancel && id_hit) && !due;
	assign pick_better = !pick_found_q || (rd_time_s1 < pick_time_q) ||
		((rd_time_s1 == pick_time_q) && (rd_id_s1 < pick_id_q));

	assign stat.scan_end = (rd_ptr_q == IdxW'(TABLE_DEPTH - 1));
	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.more     = is_expire && pick_found_q && (due_cnt_q > CntW'(1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= command;
			id_q   <= timer_id[IdW-1:0];
			time_q <= when_time;
		end
	end

	always_ff @(posedge clk) begin
		rd_time_s1 <= mem_time[rd_ptr_q];
		rd_id_s1   <= mem_id[rd_ptr_q];
		idx_s1     <= rd_ptr_q;
		if (cmd.emit && add_ok) begin
			mem_time[free_idx_q] <= time_q;
			mem_id[free_idx_q]   <= id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			vld_s1      <= 1'b0;
			rd_ptr_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd;
			if (cmd.clr) begin
				rd_ptr_q <= '0;
			end else if (cmd.rd) begin
				rd_ptr_q <= rd_ptr_q + IdxW'(1);
			end
			if (cmd.emit) begin
				if (add_ok) begin
					valid_q[free_idx_q] <= 1'b1;
				end
				if (is_cancel && dup_q) begin
					valid_q[hit_idx_q] <= 1'b0;
				end
				if (is_expire && pick_found_q) begin
					valid_q[pick_idx_q] <= 1'b0;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			dup_q        <= 1'b0;
			free_found_q <= 1'b0;
			min_any_q    <= 1'b0;
			pick_found_q <= 1'b0;
			due_cnt_q    <= '0;
		end else if (vld_s1) begin
			if (id_hit) begin
				dup_q     <= 1'b1;
				hit_idx_q <= idx_s1;
			end
			if (!e_valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
			if (counts && (!min_any_q || rd_time_s1 < min_q)) begin
				min_any_q <= 1'b1;
				min_q     <= rd_time_s1;
			end
			if (due) begin
				due_cnt_q <= due_cnt_q + CntW'(1);
				if (pick_better) begin
					pick_found_q <= 1'b1;
					pick_idx_q   <= idx_s1;
					pick_time_q  <= rd_time_s1;
					pick_id_q    <= rd_id_s1;
				end
			end
		end
	end

	// result word
	logic [KIND_W-1:0] kind_d;
	logic              ec_d, found_d, nv_d, last_d;
	logic [ID_W-1:0]   eid_d;
	logic [TIME_W-1:0] etime_d, nx_d;

	always_comb begin
		kind_d  = KIND_NONE_DUE;
		ec_d    = 1'b0;
		found_d = 1'b0;
		eid_d   = '0;
		etime_d = '0;
		nv_d    = min_any_q;
		nx_d    = min_any_q ? min_q : '0;
		last_d  = 1'b1;
		case (cmd_q)
			CMD_ADD: begin
				if (dup_q) begin
					kind_d = KIND_DUP;
				end else if (!free_found_q) begin
					kind_d = KIND_FULL;
				end else begin
					kind_d = KIND_ADDED;
					ec_d   = !min_any_q || (time_q < min_q);
					nv_d   = 1'b1;
					nx_d   = ec_d ? time_q : min_q;
				end
			end
			CMD_CANCEL: begin
				kind_d  = KIND_CANCEL;
				found_d = dup_q;
			end
			CMD_EXPIRE: begin
				if (pick_found_q) begin
					kind_d  = KIND_EXPIRED;
					eid_d   = ID_W'(pick_id_q);
					etime_d = pick_time_q;
					last_d  = !(due_cnt_q > CntW'(1));
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind             <= kind_d;
			earliest_changed <= ec_d;
			found            <= found_d;
			expired_id       <= eid_d;
			expired_time     <= etime_d;
			next_valid       <= nv_d;
			next_expiry      <= nx_d;
			last             <= last_d;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import stq_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int RANDOM_WORDS = 190;
	localparam int SETTLE = 100;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              earliest_changed;
		logic              found;
		logic [ID_W-1:0]   expired_id;
		logic [TIME_W-1:0] expired_time;
		logic              next_valid;
		logic [TIME_W-1:0] next_expiry;
		logic              last;
	} result_t;

	class timer_board;
		bit                in_use[TABLE_DEPTH];
		logic [TIME_W-1:0] due_at[TABLE_DEPTH];
		logic [ID_W-1:0]   owner[TABLE_DEPTH];
		result_t           waiting[$];
		int                errors;
		int                seen;

		function bit earliest(output logic [TIME_W-1:0] t);
			bit any;
			any = 1'b0;
			t = '0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (in_use[i] && (!any || due_at[i] < t)) begin
					t = due_at[i];
					any = 1'b1;
				end
			end
			return any;
		endfunction

		function int slot_of(logic [ID_W-1:0] id);
			for (int i = 0; i < TABLE_DEPTH; i++)
				if (in_use[i] && owner[i] == id)
					return i;
			return -1;
		endfunction

		function bit pending_id(output logic [ID_W-1:0] id);
			logic [ID_W-1:0] ids[$];
			id = '0;
			for (int i = 0; i < TABLE_DEPTH; i++)
				if (in_use[i])
					ids.push_back(owner[i]);
			if (ids.size() == 0)
				return 1'b0;
			id = ids[$urandom_range(0, ids.size() - 1)];
			return 1'b1;
		endfunction

		function int outstanding();
			return waiting.size();
		endfunction

		function void push(logic [KIND_W-1:0] k, bit ec, bit fnd, logic [ID_W-1:0] eid,
				logic [TIME_W-1:0] et, bit lst);
			result_t r;
			logic [TIME_W-1:0] nx;
			r.kind = k;
			r.earliest_changed = ec;
			r.found = fnd;
			r.expired_id = eid;
			r.expired_time = et;
			r.next_valid = earliest(nx);
			r.next_expiry = nx;
			r.last = lst;
			waiting.push_back(r);
		endfunction

		function void note_word(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
				logic [TIME_W-1:0] t);
			int s;
			int pick;
			bit ec;
			bit due[TABLE_DEPTH];
			logic [TIME_W-1:0] cur;
			int order[$];
			case (cmd)
			CMD_ADD: begin
				s = slot_of(id);
				if (s >= 0) begin
					push(KIND_DUP, 0, 0, '0, '0, 1);
				end else begin
					for (int i = TABLE_DEPTH - 1; i >= 0; i--)
						if (!in_use[i])
							s = i;
					if (s < 0) begin
						push(KIND_FULL, 0, 0, '0, '0, 1);
					end else begin
						ec = !earliest(cur) || t < cur;
						in_use[s] = 1'b1;
						due_at[s] = t;
						owner[s] = id;
						push(KIND_ADDED, ec, 0, '0, '0, 1);
					end
				end
			end
			CMD_CANCEL: begin
				s = slot_of(id);
				if (s >= 0)
					in_use[s] = 1'b0;
				push(KIND_CANCEL, 0, s >= 0, '0, '0, 1);
			end
			CMD_EXPIRE: begin
				for (int i = 0; i < TABLE_DEPTH; i++)
					due[i] = in_use[i] && due_at[i] <= t;
				pick = 0;
				while (pick >= 0) begin
					pick = -1;
					for (int i = 0; i < TABLE_DEPTH; i++) begin
						if (due[i] && (pick < 0 || due_at[i] < due_at[pick] ||
								(due_at[i] == due_at[pick] && owner[i] < owner[pick])))
							pick = i;
					end
					if (pick >= 0) begin
						due[pick] = 1'b0;
						in_use[pick] = 1'b0;
						order.push_back(pick);
					end
				end
				if (order.size() == 0) begin
					push(KIND_NONE_DUE, 0, 0, '0, '0, 1);
				end else begin
					foreach (order[k])
						push(KIND_EXPIRED, 0, 0, owner[order[k]], due_at[order[k]],
							k == order.size() - 1);
				end
			end
			default: ;
			endcase
		endfunction

		task report(string what);
			errors++;
			if (errors <= 40)
				$display("%0t mismatch: %s", $realtime, what);
		endtask

		task check_word(result_t got);
			result_t want;
			seen++;
			if (waiting.size() == 0) begin
				report($sformatf("unexpected word, kind %0d", got.kind));
				return;
			end
			want = waiting.pop_front();
			if (got.kind !== want.kind)
				report($sformatf("kind %0d, want %0d", got.kind, want.kind));
			if (got.earliest_changed !== want.earliest_changed)
				report($sformatf("earliest_changed %0b, want %0b",
					got.earliest_changed, want.earliest_changed));
			if (got.found !== want.found)
				report($sformatf("found %0b, want %0b", got.found, want.found));
			if (got.expired_id !== want.expired_id)
				report($sformatf("expired_id %h, want %h", got.expired_id, want.expired_id));
			if (got.expired_time !== want.expired_time)
				report($sformatf("expired_time %h, want %h",
					got.expired_time, want.expired_time));
			if (got.next_valid !== want.next_valid)
				report($sformatf("next_valid %0b, want %0b", got.next_valid, want.next_valid));
			if (got.next_expiry !== want.next_expiry)
				report($sformatf("next_expiry %h, want %h",
					got.next_expiry, want.next_expiry));
			if (got.last !== want.last)
				report($sformatf("last %0b, want %0b", got.last, want.last));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [CMD_W-1:0]  command = CMD_ADD;
	logic [ID_W-1:0]   timer_id = '0;
	logic [TIME_W-1:0] when_time = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [KIND_W-1:0] kind;
	logic              earliest_changed;
	logic              found;
	logic [ID_W-1:0]   expired_id;
	logic [TIME_W-1:0] expired_time;
	logic              next_valid;
	logic [TIME_W-1:0] next_expiry;
	logic              last;

	timer_board board = new();
	bit quiet = 1'b0;

	sorted_timer_queue #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.ID_BITS(ID_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.timer_id(timer_id),
		.when_time(when_time),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.earliest_changed(earliest_changed),
		.found(found),
		.expired_id(expired_id),
		.expired_time(expired_time),
		.next_valid(next_valid),
		.next_expiry(next_expiry),
		.last(last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [TIME_W-1:0] rand_time();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[TIME_W-1:0];
	endfunction

	task automatic idle(int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic put_word(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
			logic [TIME_W-1:0] t);
		int r;
		@(negedge clk);
		in_valid <= 1'b1;
		command <= cmd;
		timer_id <= id;
		when_time <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_word(cmd, id, t);
		r = $urandom_range(0, 99);
		if (!quiet && r >= 50)
			idle(r < 92 ? $urandom_range(1, 3) : $urandom_range(15, 50));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : result_check
		result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.kind = kind;
			got.earliest_changed = earliest_changed;
			got.found = found;
			got.expired_id = expired_id;
			got.expired_time = expired_time;
			got.next_valid = next_valid;
			got.next_expiry = next_expiry;
			got.last = last;
			board.check_word(got);
		end
	end

	initial begin : receiver
		int run;
		int hold;
		bit long_done;
		long_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!long_done && board.seen >= 60) begin
				long_done = 1'b1;
				@(negedge clk);
				out_ready <= 1'b0;
				hold = 0;
				while (hold < 400) begin
					@(negedge clk);
					hold++;
				end
			end
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
			@(negedge clk);
			out_ready <= 1'b1;
			repeat (run - 1) @(negedge clk);
			hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
			if (hold > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (hold - 1) @(negedge clk);
			end
		end
	end

	initial begin : stimulus
		int counted;
		int r;
		int add_share;
		logic [ID_W-1:0] id;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] t;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		put_word(CMD_EXPIRE, 16'h0000, '0);
		put_word(CMD_CANCEL, 16'hFFFF, TIME_MAX);
		put_word(CMD_ADD, 16'h0000, TIME_MAX);
		put_word(CMD_ADD, 16'hFFFF, '0);
		put_word(CMD_ADD, 16'h0001, '0);
		put_word(CMD_ADD, 16'h0000, 63'd5);
		put_word(CMD_ADD, 16'h1234, 63'd5);
		put_word(CMD_EXPIRE, 16'h0000, '0);
		put_word(CMD_CANCEL, 16'h1234, '0);
		put_word(CMD_CANCEL, 16'h1234, '0);
		for (int i = 0; i < TABLE_DEPTH - 1; i++)
			put_word(CMD_ADD, ID_W'(16'h0100 + i), TIME_W'(1000 + (i % 5)));
		put_word(CMD_ADD, 16'hABCD, 63'd1);
		put_word(CMD_ADD, 16'h0100, 63'd1);
		put_word(CMD_UNUSED, 16'hFFFF, TIME_MAX);
		put_word(CMD_EXPIRE, 16'hFFFF, TIME_MAX);
		drain();

		now = rand_time() >> 15;
		counted = 0;
		while (counted < RANDOM_WORDS) begin
			quiet = (counted % 50) >= 40;
			if (counted == 110)
				drain();
			add_share = (counted % 60 < 20) ? 85 : 45;
			r = $urandom_range(0, 99);
			if (r < 3) begin
				put_word(CMD_UNUSED, ID_W'($urandom), rand_time());
			end else begin
				r = $urandom_range(0, 99);
				if (r < add_share) begin
					r = $urandom_range(0, 99);
					if (r < 15 && board.pending_id(id))
						;
					else if (r < 60)
						id = ID_W'($urandom_range(0, 63));
					else
						id = ID_W'($urandom);
					r = $urandom_range(0, 99);
					if (r < 3)
						t = TIME_MAX;
					else if (r < 12)
						t = rand_time();
					else
						t = now + $urandom_range(0, 300);
					put_word(CMD_ADD, id, t);
				end else if (r < add_share + (100 - add_share) / 3) begin
					if ($urandom_range(0, 9) < 3 || !board.pending_id(id))
						id = ID_W'($urandom);
					put_word(CMD_CANCEL, id, rand_time());
				end else begin
					now = now + $urandom_range(0, 120);
					r = $urandom_range(0, 99);
					if (r < 3)
						t = TIME_MAX;
					else if (r < 8)
						t = rand_time();
					else
						t = now;
					put_word(CMD_EXPIRE, ID_W'($urandom), t);
				end
				counted++;
			end
		end

		quiet = 1'b0;
		drain();
		repeat (SETTLE) @(posedge clk);
		if (board.errors == 0)
			$display("** sorted_timer_queue: PASSED **");
		else
			$display("** sorted_timer_queue: FAILED **");
		$finish;
	end

	initial begin : watchdog
		#(20_000_000);
		$display("** sorted_timer_queue: FAILED **");
		$finish;
	end

endmodule

// ===== sorted_timer_queue.f =====
hdl/stq_pkg.sv
hdl/stq_ctrl.sv
hdl/stq_dp.sv
hdl/sorted_timer_queue.sv
test/testbench.sv
